[sv/bbpe_pkg.sv]
// Shared types and constants for the bicubic Bezier patch evaluator.
// No dependencies; used by bbpe_mac and bicubic_bezier_patch_eval.
`default_nettype none

package bbpe_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int UV_BITS    = 16;
  localparam int UV_W       = UV_BITS + 1;
  localparam int NORMAL_W   = 64;
  localparam int LIMB_W     = 32;
  localparam int OPND_LIMBS = 4;
  localparam int OPND_W     = LIMB_W * OPND_LIMBS;
  localparam int ACC_W      = 2 * OPND_W;
  localparam int PT_SHIFT   = 6 * UV_BITS;
  localparam int NRM_SHIFT  = 10 * UV_BITS + FRAC_BITS;
  localparam int BW_W       = 3 * UV_BITS + 1;
  localparam int DW_W       = 2 * UV_BITS + 4;

  localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_BITS;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  typedef struct packed {
    logic                      func;
    logic [1:0]                row;
    logic [1:0]                col;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [UV_W-1:0]           param_u;
    logic [UV_W-1:0]           param_v;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
    logic signed [COORD_W-1:0]  point_z;
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
  } out_item_t;

  // Command to the limb-serial multiply-accumulate unit
  typedef struct packed {
    logic       start;
    logic       clear;
    logic       sub;
    logic [1:0] na_m1;
    logic [1:0] nb_m1;
  } mac_cmd_t;

endpackage

`default_nettype wire

[sv/bbpe_mac.sv]
// Limb-serial signed multiply-accumulate: acc +/-= a * b, one 32x32 product per cycle.
// Depends on bbpe_pkg.
`default_nettype none

module bbpe_mac (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire bbpe_pkg::mac_cmd_t              cmd,
  input  wire logic signed [bbpe_pkg::OPND_W-1:0] a_in,
  input  wire logic signed [bbpe_pkg::OPND_W-1:0] b_in,
  output logic                                 done,
  output logic signed [bbpe_pkg::ACC_W-1:0]    acc
);

  logic [bbpe_pkg::OPND_W-1:0]   a_mag_r, b_mag_r;
  logic                          neg_r;
  logic [1:0]                    na_m1_r, nb_m1_r, ia_r, ib_r;
  logic                          busy_r, pv_r, last_r, done_r;
  logic [2*bbpe_pkg::LIMB_W-1:0] prod_r;
  logic [2:0]                    sh_r;
  logic [bbpe_pkg::ACC_W-1:0]    acc_r;
  logic [bbpe_pkg::ACC_W-1:0]    term;
  logic [bbpe_pkg::LIMB_W-1:0]   a_limb, b_limb;

  assign a_limb = a_mag_r[{ia_r, 5'd0} +: bbpe_pkg::LIMB_W];
  assign b_limb = b_mag_r[{ib_r, 5'd0} +: bbpe_pkg::LIMB_W];
  assign term   = bbpe_pkg::ACC_W'(prod_r) << {sh_r, 5'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // latch operand magnitudes and the sign of the product
      if (cmd.start) begin
        a_mag_r <= a_in[bbpe_pkg::OPND_W-1] ? (~a_in + 1'b1) : a_in;
        b_mag_r <= b_in[bbpe_pkg::OPND_W-1] ? (~b_in + 1'b1) : b_in;
        neg_r   <= a_in[bbpe_pkg::OPND_W-1] ^ b_in[bbpe_pkg::OPND_W-1] ^ cmd.sub;
        na_m1_r <= cmd.na_m1;
        nb_m1_r <= cmd.nb_m1;
        ia_r    <= 2'd0;
        ib_r    <= 2'd0;
        busy_r  <= 1'b1;
        if (cmd.clear) begin
          acc_r <= '0;
        end
      end
      // form one limb product per cycle
      if (busy_r) begin
        prod_r <= a_limb * b_limb;
        sh_r   <= 3'(ia_r) + 3'(ib_r);
        pv_r   <= 1'b1;
        last_r <= (ia_r == na_m1_r) && (ib_r == nb_m1_r);
        if (ib_r == nb_m1_r) begin
          ib_r <= 2'd0;
          ia_r <= ia_r + 2'd1;
          if (ia_r == na_m1_r) begin
            busy_r <= 1'b0;
          end
        end else begin
          ib_r <= ib_r + 2'd1;
        end
      end else begin
        pv_r <= 1'b0;
      end
      // fold the shifted product into the accumulator
      if (pv_r) begin
        acc_r  <= neg_r ? (acc_r - term) : (acc_r + term);
        done_r <= last_r;
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

[sv/bicubic_bezier_patch_eval.sv]
// Top level of the bicubic Bezier patch evaluator: control point memory and sequencer.
// Depends on bbpe_pkg and bbpe_mac.
//
//   channel | ports                       | beat
//   --------+-----------------------------+------------------------------
//   input   | in_valid, in_stall, in_item | load one point or evaluate
//   result  | out_valid, out_stall, out_item | point and normal per evaluate
//
// A load beat is written in the cycle it is accepted. An evaluate beat reaches the output
// register after the single 32x32 limb multiplier of the MAC unit has worked through 96
// weight x point products, 36 weight x row- or column-sum products and 6 cross-product
// terms of 16 limbs. in_stall is high from an evaluate beat until its result enters the
// output register. A result held by out_stall does not block loads. Reset is synchronous;
// the control point memory is not cleared.
`default_nettype none

module bicubic_bezier_patch_eval (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire bbpe_pkg::in_item_t in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output bbpe_pkg::out_item_t out_item
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WGT1, ST_WGT2, ST_RD, ST_MSTART, ST_MWAIT,
    ST_SSTART, ST_SWAIT, ST_XSTART, ST_XWAIT, ST_DONE
  } state_t;

  state_t state_r;

  // control point memory, one array per coordinate
  logic [bbpe_pkg::COORD_W-1:0] mem_x[16];
  logic [bbpe_pkg::COORD_W-1:0] mem_y[16];
  logic [bbpe_pkg::COORD_W-1:0] mem_z[16];
  logic [bbpe_pkg::COORD_W-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic [3:0]                   rd_addr;

  logic [bbpe_pkg::UV_W-1:0]   u_r, v_r;
  logic [bbpe_pkg::UV_W-1:0]   a_r[2], t_r[2];
  logic [2*bbpe_pkg::UV_W-1:0] tt_r[2], ta_r[2], aa_r[2];
  logic [bbpe_pkg::BW_W-1:0]   wb_r[2][4];
  logic signed [bbpe_pkg::DW_W-1:0] wd_r[2][4];

  logic signed [bbpe_pkg::OPND_W-1:0]   rs_r[4], cs_r[4], gu_r[3], gv_r[3];
  logic signed [bbpe_pkg::COORD_W-1:0]  pt_r[3];
  logic signed [bbpe_pkg::NORMAL_W-1:0] nrm_r[3];

  logic [1:0] c_r, i_r, j_r, m_r;
  logic       k_r, s_r;

  logic                out_valid_r;
  bbpe_pkg::out_item_t out_item_r;

  bbpe_pkg::mac_cmd_t                 cmd;
  logic signed [bbpe_pkg::OPND_W-1:0] opa, opb;
  logic                               mac_done;
  logic signed [bbpe_pkg::ACC_W-1:0]  acc;

  logic                               in_acc;
  logic [bbpe_pkg::COORD_W-1:0]       rd_coord;
  logic [1:0]                         p_idx, q_idx;
  logic [bbpe_pkg::ACC_W-1:0]         trunc_sum;
  logic [bbpe_pkg::ACC_W-bbpe_pkg::NRM_SHIFT-1:0] nrm_sh;
  logic signed [bbpe_pkg::NORMAL_W-1:0] nrm_sat;
  logic [bbpe_pkg::UV_W-1:0]          par_sat[2];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // read address: rows for the u sums, columns for the v sums
  assign rd_addr = k_r ? {j_r, i_r} : {i_r, j_r};

  always_ff @(posedge clk) begin
    if (in_acc && in_item.func == bbpe_pkg::FUNC_LOAD) begin
      mem_x[{in_item.row, in_item.col}] <= in_item.coord_x;
      mem_y[{in_item.row, in_item.col}] <= in_item.coord_y;
      mem_z[{in_item.row, in_item.col}] <= in_item.coord_z;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
    rd_z_q <= mem_z[rd_addr];
  end

  always_comb begin
    case (c_r)
      2'd1:    rd_coord = rd_y_q;
      2'd2:    rd_coord = rd_z_q;
      default: rd_coord = rd_x_q;
    endcase
  end

  always_comb begin
    case (c_r)
      2'd1:    begin p_idx = 2'd2; q_idx = 2'd0; end
      2'd2:    begin p_idx = 2'd0; q_idx = 2'd1; end
      default: begin p_idx = 2'd1; q_idx = 2'd2; end
    endcase
  end

  // operand and command selection for the MAC unit
  always_comb begin
    cmd = '0;
    opa = '0;
    opb = '0;
    case (state_r)
      ST_MSTART: begin
        cmd.start = 1'b1;
        cmd.clear = (j_r == 2'd0);
        cmd.na_m1 = 2'd1;
        cmd.nb_m1 = 2'd0;
        opa = bbpe_pkg::OPND_W'(wb_r[!k_r][j_r]);
        opb = bbpe_pkg::OPND_W'($signed(rd_coord));
      end
      ST_SSTART: begin
        cmd.start = 1'b1;
        cmd.clear = (i_r == 2'd0);
        cmd.na_m1 = 2'd1;
        cmd.nb_m1 = 2'd2;
        case (m_r)
          2'd1:    opa = bbpe_pkg::OPND_W'(wd_r[0][i_r]);
          2'd2:    opa = bbpe_pkg::OPND_W'(wd_r[1][i_r]);
          default: opa = bbpe_pkg::OPND_W'(wb_r[0][i_r]);
        endcase
        opb = (m_r == 2'd2) ? cs_r[i_r] : rs_r[i_r];
      end
      ST_XSTART: begin
        cmd.start = 1'b1;
        cmd.clear = !s_r;
        cmd.sub   = s_r;
        cmd.na_m1 = 2'd3;
        cmd.nb_m1 = 2'd3;
        opa = s_r ? gu_r[q_idx] : gu_r[p_idx];
        opb = s_r ? gv_r[p_idx] : gv_r[q_idx];
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  bbpe_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .a_in (opa),
    .b_in (opb),
    .done (mac_done),
    .acc  (acc)
  );

  // round the point toward zero; floor and saturate the normal
  assign trunc_sum = acc + (acc[bbpe_pkg::ACC_W-1]
                     ? ((bbpe_pkg::ACC_W'(1) << bbpe_pkg::PT_SHIFT) - 1'b1)
                     : '0);
  assign nrm_sh = acc[bbpe_pkg::ACC_W-1:bbpe_pkg::NRM_SHIFT];
  always_comb begin
    if ((&nrm_sh[$bits(nrm_sh)-1:bbpe_pkg::NORMAL_W-1]) ||
        !(|nrm_sh[$bits(nrm_sh)-1:bbpe_pkg::NORMAL_W-1])) begin
      nrm_sat = nrm_sh[bbpe_pkg::NORMAL_W-1:0];
    end else if (acc[bbpe_pkg::ACC_W-1]) begin
      nrm_sat = {1'b1, {(bbpe_pkg::NORMAL_W-1){1'b0}}};
    end else begin
      nrm_sat = {1'b0, {(bbpe_pkg::NORMAL_W-1){1'b1}}};
    end
  end

  // clamp parameters above one
  assign par_sat[0] = (u_r > bbpe_pkg::UV_ONE) ? bbpe_pkg::UV_ONE : u_r;
  assign par_sat[1] = (v_r > bbpe_pkg::UV_ONE) ? bbpe_pkg::UV_ONE : v_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      c_r <= 2'd0; i_r <= 2'd0; j_r <= 2'd0; m_r <= 2'd0;
      k_r <= 1'b0; s_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_item.func == bbpe_pkg::FUNC_EVAL) begin
            u_r     <= in_item.param_u;
            v_r     <= in_item.param_v;
            state_r <= ST_WGT1;
          end
        end
        ST_WGT1: begin
          for (int s = 0; s < 2; s++) begin
            a_r[s]  <= par_sat[s];
            t_r[s]  <= bbpe_pkg::UV_ONE - par_sat[s];
            tt_r[s] <= (bbpe_pkg::UV_ONE - par_sat[s]) * (bbpe_pkg::UV_ONE - par_sat[s]);
            ta_r[s] <= (bbpe_pkg::UV_ONE - par_sat[s]) * par_sat[s];
            aa_r[s] <= par_sat[s] * par_sat[s];
          end
          state_r <= ST_WGT2;
        end
        ST_WGT2: begin
          for (int s = 0; s < 2; s++) begin
            wb_r[s][0] <= bbpe_pkg::BW_W'(51'(tt_r[s]) * 51'(t_r[s]));
            wb_r[s][1] <= bbpe_pkg::BW_W'(51'(tt_r[s]) * 51'(a_r[s]) * 51'd3);
            wb_r[s][2] <= bbpe_pkg::BW_W'(51'(aa_r[s]) * 51'(t_r[s]) * 51'd3);
            wb_r[s][3] <= bbpe_pkg::BW_W'(51'(aa_r[s]) * 51'(a_r[s]));
            wd_r[s][0] <= -($signed(bbpe_pkg::DW_W'(tt_r[s])) * 3);
            wd_r[s][1] <= $signed(bbpe_pkg::DW_W'(tt_r[s])) * 3
                          - $signed(bbpe_pkg::DW_W'(ta_r[s])) * 6;
            wd_r[s][2] <= $signed(bbpe_pkg::DW_W'(ta_r[s])) * 6
                          - $signed(bbpe_pkg::DW_W'(aa_r[s])) * 3;
            wd_r[s][3] <= $signed(bbpe_pkg::DW_W'(aa_r[s])) * 3;
          end
          c_r <= 2'd0; k_r <= 1'b0; i_r <= 2'd0; j_r <= 2'd0;
          state_r <= ST_RD;
        end
        ST_RD: begin
          state_r <= ST_MSTART;
        end
        ST_MSTART: begin
          state_r <= ST_MWAIT;
        end
        // accumulate row and column sums of weighted points
        ST_MWAIT: begin
          if (mac_done) begin
            if (j_r == 2'd3) begin
              if (k_r) begin
                cs_r[i_r] <= acc[bbpe_pkg::OPND_W-1:0];
              end else begin
                rs_r[i_r] <= acc[bbpe_pkg::OPND_W-1:0];
              end
              j_r <= 2'd0;
              if (i_r == 2'd3) begin
                i_r <= 2'd0;
                if (k_r) begin
                  m_r     <= 2'd0;
                  state_r <= ST_SSTART;
                end else begin
                  k_r     <= 1'b1;
                  state_r <= ST_RD;
                end
              end else begin
                i_r     <= i_r + 2'd1;
                state_r <= ST_RD;
              end
            end else begin
              j_r     <= j_r + 2'd1;
              state_r <= ST_RD;
            end
          end
        end
        ST_SSTART: begin
          state_r <= ST_SWAIT;
        end
        // point and the two partial derivatives for this coordinate
        ST_SWAIT: begin
          if (mac_done) begin
            if (i_r == 2'd3) begin
              case (m_r)
                2'd1:    gu_r[c_r] <= acc[bbpe_pkg::OPND_W-1:0];
                2'd2:    gv_r[c_r] <= acc[bbpe_pkg::OPND_W-1:0];
                default: pt_r[c_r] <=
                  trunc_sum[bbpe_pkg::PT_SHIFT +: bbpe_pkg::COORD_W];
              endcase
              i_r <= 2'd0;
              if (m_r == 2'd2) begin
                if (c_r == 2'd2) begin
                  c_r     <= 2'd0;
                  s_r     <= 1'b0;
                  state_r <= ST_XSTART;
                end else begin
                  c_r     <= c_r + 2'd1;
                  k_r     <= 1'b0;
                  j_r     <= 2'd0;
                  state_r <= ST_RD;
                end
              end else begin
                m_r     <= m_r + 2'd1;
                state_r <= ST_SSTART;
              end
            end else begin
              i_r     <= i_r + 2'd1;
              state_r <= ST_SSTART;
            end
          end
        end
        ST_XSTART: begin
          state_r <= ST_XWAIT;
        end
        // cross product of the derivatives, two terms per component
        ST_XWAIT: begin
          if (mac_done) begin
            if (!s_r) begin
              s_r     <= 1'b1;
              state_r <= ST_XSTART;
            end else begin
              nrm_r[c_r] <= nrm_sat;
              s_r        <= 1'b0;
              if (c_r == 2'd2) begin
                state_r <= ST_DONE;
              end else begin
                c_r     <= c_r + 2'd1;
                state_r <= ST_XSTART;
              end
            end
          end
        end
        // hold until the output register is free
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_item_r.point_x  <= pt_r[0];
            out_item_r.point_y  <= pt_r[1];
            out_item_r.point_z  <= pt_r[2];
            out_item_r.normal_x <= nrm_r[0];
            out_item_r.normal_y <= nrm_r[1];
            out_item_r.normal_z <= nrm_r[2];
            out_valid_r         <= 1'b1;
            state_r             <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
